// File: rtl/core/image_conv3x3_smooth_sharpen_macros.svh
// Assertion macros used by the image convolution checker.
`ifndef IMAGE_CONV3X3_SMOOTH_SHARPEN_MACROS_SVH
`define IMAGE_CONV3X3_SMOOTH_SHARPEN_MACROS_SVH

// Checked while out of reset.
`define IMGCONV_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("imgconv: assertion failed");

// Checked at every edge, reset included.
`define IMGCONV_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("imgconv: assertion failed");

`endif

// File: rtl/core/imgconv_pkg.sv
// Types, register indexes and kernel weights for the 3x3 image convolution.
package imgconv_pkg;

	typedef logic [7:0] chan_t;
	// index 0 red, 1 green, 2 blue
	typedef logic [2:0][7:0] pix_t;

	// one window column, three rows
	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} col_t;

	// one line store entry: rows r-2 and r-1
	typedef struct packed {
		pix_t upper;
		pix_t lower;
	} lines_t;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

	localparam logic [11:0] WIDTH_RESET  = 12'd640;
	localparam logic [11:0] HEIGHT_RESET = 12'd480;
	localparam logic [11:0] MIN_SIZE     = 12'd3;
	localparam logic [11:0] MAX_HEIGHT   = 12'd2048;

	localparam logic MODE_SMOOTH  = 1'b0;
	localparam logic MODE_SHARPEN = 1'b1;

	localparam int POS_W = 11;
	localparam int SUM_W = 14;

	// row-major 3x3 weights, [mode][tap]
	localparam logic signed [4:0] KERNEL_W [2][9] = '{
		'{5'sd1, 5'sd2, 5'sd1, 5'sd2, 5'sd4, 5'sd2, 5'sd1, 5'sd2, 5'sd1},
		'{-5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd9, -5'sd1, -5'sd1, -5'sd1, -5'sd1}
	};

endpackage

// File: rtl/core/imgconv_linebuf.sv
// Two-row line store in one memory, registered read, one write port.
module imgconv_linebuf #(
	parameter int DEPTH = 2048
) (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output imgconv_pkg::lines_t        rd_data,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  imgconv_pkg::lines_t        wr_data
);

	imgconv_pkg::lines_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/core/imgconv_cell.sv
// Window cell: holds one three-row column and hands it on to the next cell.
module imgconv_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift,
	input  imgconv_pkg::col_t   din,
	output imgconv_pkg::col_t   dout
);

	imgconv_pkg::col_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= din;
		end
	end

	assign dout = col_q;

endmodule

// File: rtl/core/imgconv_kernel.sv
// One channel of the 3x3 kernel: weighted sum register, then scale or clamp.
module imgconv_kernel (
	input  logic                  clk,
	input  logic                  en,
	input  logic                  mode,
	input  imgconv_pkg::chan_t    win [9],
	output imgconv_pkg::chan_t    result
);

	logic signed [imgconv_pkg::SUM_W-1:0] sum;
	logic signed [imgconv_pkg::SUM_W-1:0] sum_s2;

	always_comb begin
		sum = '0;
		for (int i = 0; i < 9; i++) begin
			sum = sum + imgconv_pkg::SUM_W'($signed({1'b0, win[i]}))
				* imgconv_pkg::SUM_W'(imgconv_pkg::KERNEL_W[mode][i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= sum;
		end
	end

	always_comb begin
		if (mode == imgconv_pkg::MODE_SMOOTH) begin
			result = sum_s2[11:4];
		end else if (sum_s2 < 0) begin
			result = 8'd0;
		end else if (sum_s2 > imgconv_pkg::SUM_W'(255)) begin
			result = 8'd255;
		end else begin
			result = sum_s2[7:0];
		end
	end

endmodule

// File: rtl/core/image_conv3x3_smooth_sharpen.sv
// An accepted pixel passes the stage 1 registers, the kernel sum register and then the output register.
// Throughput: one pixel per cycle; the line store read stage and the kernel sum stage
// advance together and stall only while a result waits on m_tready.
// Pixels before column 2 or row 2 of a frame give no result.
// Reset: counters and window cleared, registers 640 x 480 smoothing; line store
// contents are undefined until written.
module image_conv3x3_smooth_sharpen #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [imgconv_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [imgconv_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [23:0]                            s_tdata,  // in_red, in_green, in_blue
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [47:0]                            m_tdata,  // out_red, out_green, out_blue,
	                                                         // out_col, out_row, 2'b0
	output logic                                   m_tlast   // frame_done
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = (CW + 1 > 12) ? CW + 1 : 12;
	localparam int PW = imgconv_pkg::POS_W;

	logic [11:0]   width_q;
	logic [11:0]   height_q;
	logic          mode_q;
	logic [CW-1:0] col_q;
	logic [PW-1:0] row_q;

	logic          cfg_hit;
	logic          adv;
	logic          accept;
	logic [WW-1:0] width_ext;
	logic [WW-1:0] w_use;
	logic [11:0]   h_use;
	logic          col_last;
	logic          row_last;
	logic          produce;

	logic                v_s1;
	logic                prod_s1;
	logic                done_s1;
	imgconv_pkg::pix_t   px_s1;
	logic [CW-1:0]       idx_s1;
	logic [PW-1:0]       ocol_s1;
	logic [PW-1:0]       orow_s1;

	logic          v_s2;
	logic          done_s2;
	logic [PW-1:0] ocol_s2;
	logic [PW-1:0] orow_s2;

	imgconv_pkg::lines_t rd_lines;
	imgconv_pkg::lines_t wr_lines;
	imgconv_pkg::col_t   cur_col;
	imgconv_pkg::col_t   chain [3];
	imgconv_pkg::chan_t  win [3][9];
	imgconv_pkg::chan_t  res [3];

	// configuration
	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index == imgconv_pkg::REG_WIDTH
		|| cfg_index == imgconv_pkg::REG_HEIGHT || cfg_index == imgconv_pkg::REG_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= imgconv_pkg::WIDTH_RESET;
			height_q <= imgconv_pkg::HEIGHT_RESET;
			mode_q   <= imgconv_pkg::MODE_SMOOTH;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				imgconv_pkg::REG_WIDTH:  width_q  <= cfg_data[11:0];
				imgconv_pkg::REG_HEIGHT: height_q <= cfg_data[11:0];
				imgconv_pkg::REG_MODE:   mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign width_ext = WW'(width_q);
	assign w_use = (width_q < imgconv_pkg::MIN_SIZE) ? WW'(imgconv_pkg::MIN_SIZE)
		: (width_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : width_ext;
	assign h_use = (height_q < imgconv_pkg::MIN_SIZE) ? imgconv_pkg::MIN_SIZE
		: (height_q > imgconv_pkg::MAX_HEIGHT) ? imgconv_pkg::MAX_HEIGHT : height_q;

	// handshake: whole pipeline moves unless the output register is stalled
	assign adv      = !(m_tvalid && !m_tready);
	assign s_tready = adv;
	assign accept   = s_tvalid && s_tready;

	assign col_last = (WW'(col_q) + WW'(1)) >= w_use;
	assign row_last = (12'(row_q) + 12'd1) >= h_use;
	assign produce  = (col_q >= CW'(2)) && (row_q >= PW'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + PW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// stage 1: line store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_s1 <= produce;
			done_s1 <= col_last && row_last;
			px_s1   <= s_tdata;
			idx_s1  <= col_q;
			ocol_s1 <= PW'(col_q - CW'(2));
			orow_s1 <= row_q - PW'(2);
		end
	end

	assign wr_lines.upper = rd_lines.lower;
	assign wr_lines.lower = px_s1;

	imgconv_linebuf #(
		.DEPTH (MAX_WIDTH)
	) u_linebuf (
		.clk     (clk),
		.rd_en   (adv),
		.rd_addr (col_q),
		.rd_data (rd_lines),
		.wr_en   (adv && v_s1),
		.wr_addr (idx_s1),
		.wr_data (wr_lines)
	);

	// window: current column, then a chain of two cells for columns c-1 and c-2
	assign cur_col.top = rd_lines.upper;
	assign cur_col.mid = rd_lines.lower;
	assign cur_col.bot = px_s1;
	assign chain[0]    = cur_col;

	for (genvar g = 0; g < 2; g++) begin : g_cell
		imgconv_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (adv && v_s1),
			.din    (chain[g]),
			.dout   (chain[g+1])
		);
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_chan
		assign win[ch][0] = chain[2].top[ch];
		assign win[ch][1] = chain[1].top[ch];
		assign win[ch][2] = chain[0].top[ch];
		assign win[ch][3] = chain[2].mid[ch];
		assign win[ch][4] = chain[1].mid[ch];
		assign win[ch][5] = chain[0].mid[ch];
		assign win[ch][6] = chain[2].bot[ch];
		assign win[ch][7] = chain[1].bot[ch];
		assign win[ch][8] = chain[0].bot[ch];

		imgconv_kernel u_kernel (
			.clk    (clk),
			.en     (adv),
			.mode   (mode_q),
			.win    (win[ch]),
			.result (res[ch])
		);
	end

	// stage 2: kernel sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1 && prod_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			done_s2 <= done_s1;
			ocol_s2 <= ocol_s1;
			orow_s2 <= orow_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {2'b00, orow_s2, ocol_s2, res[2], res[1], res[0]};
			m_tlast <= done_s2;
		end
	end

endmodule

// File: rtl/core/imgconv_checker.sv
// Port-level checker for the image convolution block, bound to the top level.
`include "image_conv3x3_smooth_sharpen_macros.svh"

module imgconv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tlast
);

	// a stalled result holds
	`IMGCONV_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> $stable({m_tvalid, m_tdata, m_tlast}))

	// input side blocks exactly while a result is stalled
	`IMGCONV_ASSERT(a_ready_tie, clk, arst_n, s_tready == !(m_tvalid && !m_tready))

	// destination row never reaches the last two rows
	`IMGCONV_ASSERT(a_row_range, clk, arst_n, m_tvalid |-> m_tdata[45:35] <= 11'd2045)

	// no result while in reset
	`IMGCONV_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !m_tvalid)

endmodule

bind image_conv3x3_smooth_sharpen imgconv_checker u_checker (.*);
